@@ rtl/bhj_pkg.sv @@
package bhj_pkg;

  // Run length limit and field widths
  localparam int unsigned MAX_WORDS   = 33554432;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned TOTAL_W     = 31;
  localparam int unsigned PAIRS_W     = 26;
  localparam int unsigned RATIO_W     = 17;
  localparam int unsigned RUN_W       = $clog2(MAX_WORDS + 1);
  localparam int unsigned POP_W       = $clog2(WORD_W + 1);
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Totals of one finished run, handed from front to back
  typedef struct packed {
    logic [TOTAL_W-1:0] diff_total;
    logic [TOTAL_W-1:0] inter_total;
    logic [TOTAL_W-1:0] union_total;
    logic [PAIRS_W-1:0] pairs_seen;
  } run_rec_t;

  // Ones in a nibble
  function automatic logic [2:0] nib_ones(input logic [3:0] n);
    case (n)
      4'h0:                         nib_ones = 3'd0;
      4'h1, 4'h2, 4'h4, 4'h8:       nib_ones = 3'd1;
      4'h7, 4'hB, 4'hD, 4'hE:       nib_ones = 3'd3;
      4'hF:                         nib_ones = 3'd4;
      default:                      nib_ones = 3'd2;
    endcase
  endfunction

  // Ones in a word, summed nibble by nibble
  function automatic logic [POP_W-1:0] word_ones(input logic [WORD_W-1:0] w);
    logic [POP_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < WORD_W / 4; i++) begin
      acc = acc + POP_W'(nib_ones(w[4*i +: 4]));
    end
    word_ones = acc;
  endfunction

  // Saturating add of a popcount to a total
  function automatic logic [TOTAL_W-1:0] total_add(input logic [TOTAL_W-1:0] total,
                                                   input logic [POP_W-1:0]   inc);
    logic [TOTAL_W:0] s;
    s = {1'b0, total} + (TOTAL_W + 1)'(inc);
    total_add = s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
  endfunction

endpackage

@@ rtl/bitvector_hamming_jaccard_top.sv @@
// Path: an item that ends a run is written to the run queue; the back end then takes it
//   and runs a bit-serial Jaccard divide, MSB first; an empty union skips the divide.
// Throughput: one word pair per cycle while the run queue has room; the back end works on
//   one run at a time until it is popped; a two-entry run queue absorbs short runs.
// Reset: synchronous active-high rst clears totals, queue and sequencer; no result is held.
module bitvector_hamming_jaccard_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [bhj_pkg::WORD_W-1:0]   word_a,
  input  logic [bhj_pkg::WORD_W-1:0]   word_b,
  input  logic                         last_word,
  output logic                         empty,
  input  logic                         pop,
  output logic [bhj_pkg::TOTAL_W-1:0]  hamming_distance,
  output logic [bhj_pkg::TOTAL_W-1:0]  intersection_count,
  output logic [bhj_pkg::RATIO_W-1:0]  jaccard_ratio,
  output logic [bhj_pkg::PAIRS_W-1:0]  pair_count,
  output logic                         union_empty
);
  import bhj_pkg::*;

  logic     in_take, rec_push, q_full, q_empty, rec_take;
  run_rec_t front_rec, back_rec;

  // Hold input off while the run queue has no room
  assign full    = q_full;
  assign in_take = push && !q_full;

  bhj_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .word_a    (word_a),
    .word_b    (word_b),
    .last_word (last_word),
    .rec_push  (rec_push),
    .rec       (front_rec)
  );

  bhj_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (front_rec),
    .q_full  (q_full),
    .rd_en   (rec_take),
    .q_empty (q_empty),
    .rd_data (back_rec)
  );

  bhj_back u_back (
    .clk                (clk),
    .rst                (rst),
    .rec_avail          (!q_empty),
    .rec                (back_rec),
    .rec_take           (rec_take),
    .empty              (empty),
    .pop                (pop),
    .hamming_distance   (hamming_distance),
    .intersection_count (intersection_count),
    .jaccard_ratio      (jaccard_ratio),
    .pair_count         (pair_count),
    .union_empty        (union_empty)
  );

endmodule

@@ rtl/bhj_front.sv @@
module bhj_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_take,
  input  logic [bhj_pkg::WORD_W-1:0]     word_a,
  input  logic [bhj_pkg::WORD_W-1:0]     word_b,
  input  logic                           last_word,
  output logic                           rec_push,
  output bhj_pkg::run_rec_t              rec
);
  import bhj_pkg::*;

  logic [TOTAL_W-1:0] inter_total, union_total, diff_total;
  logic [PAIRS_W-1:0] pairs_seen;
  logic [RUN_W-1:0]   run_len;

  logic [TOTAL_W-1:0] inter_next, union_next, diff_next;
  logic [PAIRS_W-1:0] pairs_next;
  logic [RUN_W-1:0]   run_len_next;
  logic               run_end;

  // Popcounts of this item folded into the running totals
  always_comb begin
    inter_next   = total_add(inter_total, word_ones(word_a & word_b));
    union_next   = total_add(union_total, word_ones(word_a | word_b));
    diff_next    = total_add(diff_total,  word_ones(word_a ^ word_b));
    pairs_next   = (&pairs_seen) ? pairs_seen : pairs_seen + PAIRS_W'(1);
    run_len_next = run_len + RUN_W'(1);
    run_end      = last_word || (run_len_next == RUN_W'(MAX_WORDS));
  end

  // Finished run goes to the queue
  always_comb begin
    rec_push        = in_take && run_end;
    rec.diff_total  = diff_next;
    rec.inter_total = inter_next;
    rec.union_total = union_next;
    rec.pairs_seen  = pairs_next;
  end

  // Totals clear at reset and after each run
  always_ff @(posedge clk) begin
    if (rst) begin
      inter_total <= '0;
      union_total <= '0;
      diff_total  <= '0;
      pairs_seen  <= '0;
      run_len     <= '0;
    end else if (in_take) begin
      if (run_end) begin
        inter_total <= '0;
        union_total <= '0;
        diff_total  <= '0;
        pairs_seen  <= '0;
        run_len     <= '0;
      end else begin
        inter_total <= inter_next;
        union_total <= union_next;
        diff_total  <= diff_next;
        pairs_seen  <= pairs_next;
        run_len     <= run_len_next;
      end
    end
  end

endmodule

@@ rtl/bhj_queue.sv @@
module bhj_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  bhj_pkg::run_rec_t wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic              q_empty,
  output bhj_pkg::run_rec_t rd_data
);
  import bhj_pkg::*;

  run_rec_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_wr, do_rd;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  // Pointer wrap
  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= ptr_inc(wr_ptr);
      if (do_rd) rd_ptr <= ptr_inc(rd_ptr);
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/bhj_back.sv @@
module bhj_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rec_avail,
  input  bhj_pkg::run_rec_t            rec,
  output logic                         rec_take,
  output logic                         empty,
  input  logic                         pop,
  output logic [bhj_pkg::TOTAL_W-1:0]  hamming_distance,
  output logic [bhj_pkg::TOTAL_W-1:0]  intersection_count,
  output logic [bhj_pkg::RATIO_W-1:0]  jaccard_ratio,
  output logic [bhj_pkg::PAIRS_W-1:0]  pair_count,
  output logic                         union_empty
);
  import bhj_pkg::*;

  localparam int unsigned STEP_W = $clog2(RATIO_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t        state, state_next;
  logic [TOTAL_W:0]   rem;
  logic [TOTAL_W-1:0] den;
  logic [RATIO_W-1:0] quot;
  logic [STEP_W-1:0]  step;

  logic [TOTAL_W:0]   rem_sub;
  logic               q_bit;
  logic [TOTAL_W-1:0] rem_keep;

  // One restoring step: quotient bit and partial remainder
  always_comb begin
    rem_sub  = rem - {1'b0, den};
    q_bit    = (rem >= {1'b0, den});
    rem_keep = q_bit ? rem_sub[TOTAL_W-1:0] : rem[TOTAL_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (rec_avail) state_next = (rec.union_total == '0) ? ST_DONE : ST_DIV;
      ST_DIV:  if (step == STEP_W'(RATIO_W - 1)) state_next = ST_DONE;
      ST_DONE: if (pop) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign rec_take = (state == ST_IDLE) && rec_avail;
  assign empty    = (state != ST_DONE);
  assign jaccard_ratio = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load a run, then one quotient bit per cycle, MSB first
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        hamming_distance   <= rec.diff_total;
        intersection_count <= rec.inter_total;
        pair_count         <= rec.pairs_seen;
        union_empty        <= (rec.union_total == '0);
        rem                <= {1'b0, rec.inter_total};
        den                <= rec.union_total;
        quot               <= '0;
        step               <= '0;
      end
      ST_DIV: begin
        quot <= {quot[RATIO_W-2:0], q_bit};
        rem  <= {rem_keep, 1'b0};
        step <= step + STEP_W'(1);
      end
      ST_DONE: begin
        quot <= quot;
      end
      default: begin
        quot <= '0;
      end
    endcase
  end

endmodule

@@ verif/bitvector_hamming_jaccard_top_tb.sv @@
module bitvector_hamming_jaccard_top_tb;

  localparam int unsigned STUCK_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned CALM_TAIL = 100;
  localparam int unsigned TARGET_PAIRS = 600;
  localparam longint unsigned Q16_ONE = 64'd65536;

  // One word pair as handed to the block
  typedef struct {
    logic [bhj_pkg::WORD_W-1:0] a;
    logic [bhj_pkg::WORD_W-1:0] b;
    logic                       last;
  } word_pair_t;

  // Figures reported at the end of one run
  typedef struct {
    logic [bhj_pkg::TOTAL_W-1:0] hdist;
    logic [bhj_pkg::TOTAL_W-1:0] inter;
    logic [bhj_pkg::RATIO_W-1:0] ratio;
    logic [bhj_pkg::PAIRS_W-1:0] pairs;
    logic                        uempty;
  } run_figures_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          push = 1'b0;
  logic                          full;
  logic [bhj_pkg::WORD_W-1:0]    word_a = '0;
  logic [bhj_pkg::WORD_W-1:0]    word_b = '0;
  logic                          last_word = 1'b0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [bhj_pkg::TOTAL_W-1:0]   hamming_distance;
  logic [bhj_pkg::TOTAL_W-1:0]   intersection_count;
  logic [bhj_pkg::RATIO_W-1:0]   jaccard_ratio;
  logic [bhj_pkg::PAIRS_W-1:0]   pair_count;
  logic                          union_empty;

  word_pair_t   pair_q[$];
  run_figures_t run_figures_q[$];

  // Running totals of the run in progress
  longint unsigned inter_sum;
  longint unsigned union_sum;
  longint unsigned diff_sum;
  longint unsigned pairs_sum;
  longint unsigned run_len;

  int unsigned mismatches = 0;
  int unsigned cyc = 0;
  int unsigned stuck = 0;
  int unsigned send_gap;
  int unsigned pop_gap;

  bitvector_hamming_jaccard_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .word_a             (word_a),
    .word_b             (word_b),
    .last_word          (last_word),
    .empty              (empty),
    .pop                (pop),
    .hamming_distance   (hamming_distance),
    .intersection_count (intersection_count),
    .jaccard_ratio      (jaccard_ratio),
    .pair_count         (pair_count),
    .union_empty        (union_empty)
  );

  always #1 clk = ~clk;

  function automatic longint unsigned sat_add(longint unsigned total, longint unsigned inc,
                                              longint unsigned limit);
    sat_add = (total + inc > limit) ? limit : total + inc;
  endfunction

  // Fold one accepted pair into the run totals; a run end yields its figures
  function automatic void fold_word_pair(logic [31:0] a, logic [31:0] b, logic last);
    longint unsigned total_max;
    longint unsigned pairs_max;
    longint unsigned q;
    run_figures_t    fig;
    total_max = (64'd1 << bhj_pkg::TOTAL_W) - 1;
    pairs_max = (64'd1 << bhj_pkg::PAIRS_W) - 1;
    inter_sum = sat_add(inter_sum, $countones(a & b), total_max);
    union_sum = sat_add(union_sum, $countones(a | b), total_max);
    diff_sum  = sat_add(diff_sum, $countones(a ^ b), total_max);
    pairs_sum = sat_add(pairs_sum, 1, pairs_max);
    run_len++;
    if (!last && run_len < bhj_pkg::MAX_WORDS) return;
    q = 0;
    if (union_sum != 0) begin
      q = (inter_sum << bhj_pkg::FRAC_BITS) / union_sum;
      if (q > Q16_ONE) q = Q16_ONE;
    end
    fig.hdist  = diff_sum[bhj_pkg::TOTAL_W-1:0];
    fig.inter  = inter_sum[bhj_pkg::TOTAL_W-1:0];
    fig.ratio  = q[bhj_pkg::RATIO_W-1:0];
    fig.pairs  = pairs_sum[bhj_pkg::PAIRS_W-1:0];
    fig.uempty = (union_sum == 0);
    run_figures_q.push_back(fig);
    inter_sum = 0;
    union_sum = 0;
    diff_sum  = 0;
    pairs_sum = 0;
    run_len   = 0;
  endfunction

  function automatic void check_field(string fname, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic void add_pair(logic [31:0] a, logic [31:0] b, logic last);
    word_pair_t p;
    p.a = a;
    p.b = b;
    p.last = last;
    pair_q.push_back(p);
  endfunction

  // Word with a shape picked at random: empty, full, one bit, sparse, dense or plain
  function automatic logic [31:0] shaped_word();
    case ($urandom_range(0, 9))
      0: shaped_word = '0;
      1: shaped_word = '1;
      2: shaped_word = 32'd1 << $urandom_range(0, 31);
      3: shaped_word = $urandom & $urandom & $urandom;
      4: shaped_word = $urandom | $urandom | $urandom;
      default: shaped_word = $urandom;
    endcase
  endfunction

  // Sender: holds push until the item is taken, idles in bursts
  always @(posedge clk) begin
    word_pair_t nxt;
    if (rst) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) fold_word_pair(word_a, word_b, last_word);
      if (!push || !full) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pair_q.size() == 0) begin
          push <= 1'b0;
        end else if (pair_q.size() > CALM_TAIL && (cyc / 50) % 3 != 0 &&
                     $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          push <= 1'b0;
        end else begin
          nxt = pair_q.pop_front();
          push <= 1'b1;
          word_a <= nxt.a;
          word_b <= nxt.b;
          last_word <= nxt.last;
        end
      end
    end
  end

  // Receiver: checks each taken result, stalls in bursts
  always @(posedge clk) begin
    run_figures_t fig;
    if (rst) begin
      pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (run_figures_q.size() == 0) begin
          $error("result with no run pending: hamming_distance %0d", hamming_distance);
          mismatches++;
        end else begin
          fig = run_figures_q.pop_front();
          check_field("hamming_distance", fig.hdist, hamming_distance);
          check_field("intersection_count", fig.inter, intersection_count);
          check_field("jaccard_ratio", fig.ratio, jaccard_ratio);
          check_field("pair_count", fig.pairs, pair_count);
          check_field("union_empty", fig.uempty, union_empty);
        end
      end
      if (pop_gap != 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (pair_q.size() > CALM_TAIL && (cyc / 70) % 3 != 1 &&
                   $urandom_range(0, 5) == 0) begin
        pop_gap = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: too long with work pending and no handshake
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst) begin
      if ((push && !full) || (pop && !empty) ||
          (pair_q.size() == 0 && !push && run_figures_q.size() == 0)) begin
        stuck <= 0;
      end else if (stuck >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stuck <= stuck + 1;
      end
    end
  end

  initial begin
    int unsigned     run_pairs;
    int unsigned     mode;
    logic [31:0]     a;
    logic [31:0]     b;
    inter_sum = 0;
    union_sum = 0;
    diff_sum  = 0;
    pairs_sum = 0;
    run_len   = 0;

    // Directed: empty union, full overlap, disjoint, truncated ratio, top bit
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    add_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b1);
    add_pair(32'h0000_0007, 32'h0000_0001, 1'b1);
    add_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_pair(32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    repeat (3) add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    add_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
    add_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
    add_pair(32'h0000_0001, 32'h0000_0000, 1'b1);
    add_pair(32'h0000_0003, 32'h0000_0001, 1'b1);

    // Random runs: mostly short, some long; content shaped per run
    while (pair_q.size() < TARGET_PAIRS) begin
      run_pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      mode = $urandom_range(0, 7);
      for (int i = 0; i < run_pairs; i++) begin
        a = shaped_word();
        case (mode)
          0: begin a = '0; b = '0; end
          1: b = a;
          2: b = a ^ (32'd1 << $urandom_range(0, 31));
          3: b = ~a;
          default: b = shaped_word();
        endcase
        add_pair(a, b, i == run_pairs - 1);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Drain: all pairs taken, all results back, then a quiet tail
    while (pair_q.size() != 0 || push) @(negedge clk);
    while (run_figures_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
